[rtl/assert_macros.svh]
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RSQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rsq assertion failed");
`define RSQ_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rsq forbidden condition");
`else
`define RSQ_ASSERT(label, clk, rst_n, prop)
`define RSQ_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/rsq_pkg.sv]
// shared types and codes of the rpn stack and queue calculator
package rsq_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_W     = 31;
    localparam int MODE_W    = 4;
    localparam int STAT_W    = 3;
    localparam int CNT_OUT_W = 7;

    localparam logic [MODE_W-1:0] MODE_PUSH = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_TOP  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_POP  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DUP  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_COND = 4'd8;
    localparam logic [MODE_W-1:0] MODE_ENQ  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_DEQ  = 4'd10;
    localparam logic [MODE_W-1:0] MODE_SAVE = 4'd11;
    localparam logic [MODE_W-1:0] MODE_LOAD = 4'd12;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FEW     = 3'd1;
    localparam logic [STAT_W-1:0] ST_DIV0    = 3'd2;
    localparam logic [STAT_W-1:0] ST_SFULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_QEMPTY  = 3'd4;
    localparam logic [STAT_W-1:0] ST_QFULL   = 3'd5;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd6;

    // stack write address select
    localparam logic [1:0] SA_CNT = 2'd0;
    localparam logic [1:0] SA_M2  = 2'd1;
    localparam logic [1:0] SA_M3  = 2'd2;

    // stack write data select
    localparam logic [2:0] SD_NUM  = 3'd0;
    localparam logic [2:0] SD_RES  = 3'd1;
    localparam logic [2:0] SD_SRD  = 3'd2;
    localparam logic [2:0] SD_COND = 3'd3;
    localparam logic [2:0] SD_QRD  = 3'd4;

    // stack count update
    localparam logic [2:0] CNT_HOLD = 3'd0;
    localparam logic [2:0] CNT_INC  = 3'd1;
    localparam logic [2:0] CNT_DEC  = 3'd2;
    localparam logic [2:0] CNT_DEC2 = 3'd3;

    typedef struct packed {
        logic              take_num;
        logic [1:0]        srd_off;
        logic              cap_b;
        logic              cap_a;
        logic              alu;
        logic [MODE_W-1:0] alu_op;
        logic              div_start;
        logic              div_cap;
        logic              sw_en;
        logic [1:0]        sw_addr;
        logic [2:0]        sw_data;
        logic [2:0]        cnt_op;
        logic              qwr;
        logic              qpop;
        logic              copy_clr;
        logic              copy_save;
        logic              copy_load;
        logic              save_regs;
        logic              load_regs;
        logic              out_load;
        logic [STAT_W-1:0] status;
        logic              top_ok;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt2;
        logic cnt_lt3;
        logic cnt_full;
        logic q_empty;
        logic q_full;
        logic b_zero;
        logic div_done;
        logic copy_done;
        logic out_busy;
    } t_dp_stat;

endpackage

[rtl/rpn_stack_queue_calculator.sv]
// push, pop and errors caught at decode go from decode to the result register; other
// commands first read their operands and execute; div runs a 32-step divider, and save
// and load sweep max(STACK_DEPTH, QUEUE_DEPTH) entries (one entry per memory per cycle)
// one command in flight at a time, the next is taken once the result is offered
// synchronous active-low reset empties stack and queue; memories are not cleared
module rpn_stack_queue_calculator
    import rsq_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // mode[3:0], number[34:4], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // status[2:0], top_value[34:3], top_valid[35],
                                  // stack_count[42:36], zero pad
);
    t_dp_cmd             cmd;
    t_dp_stat            stat;
    logic [STAT_W-1:0]   status;
    logic [DATA_W-1:0]   top_value;
    logic                top_valid;
    logic [CNT_OUT_W-1:0] stack_count;

    rsq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_tvalid),
        .o_ready(s_tready),
        .i_mode (s_tdata[MODE_W-1:0]),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    rsq_dp #(
        .STACK_DEPTH(STACK_DEPTH),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_number     (s_tdata[MODE_W+NUM_W-1:MODE_W]),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_status     (status),
        .o_top_value  (top_value),
        .o_top_valid  (top_valid),
        .o_stack_count(stack_count)
    );

    assign m_tdata = {5'd0, stack_count, top_valid, top_value, status};
endmodule

[rtl/rsq_div.sv]
// iterative signed 32-bit divider, one quotient bit per cycle
module rsq_div
    import rsq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_busy,
    output logic              o_done,
    output logic [DATA_W-1:0] o_q
);
    localparam int SCW = $clog2(DATA_W);

    logic              r_busy, r_done, r_neg;
    logic [SCW-1:0]    r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_quo, r_mb;
    logic [DATA_W:0]   rem_sh, diff;

    assign rem_sh = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SCW'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_a[DATA_W-1] ? (DATA_W'(0) - i_a) : i_a;
            r_mb  <= i_b[DATA_W-1] ? (DATA_W'(0) - i_b) : i_b;
            r_neg <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                r_rem <= diff;
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = r_neg ? (DATA_W'(0) - r_quo) : r_quo;
endmodule

[rtl/rsq_dp.sv]
// datapath: stack and queue memories, saved copies, alu and result register
module rsq_dp
    import rsq_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [NUM_W-1:0]     i_number,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [DATA_W-1:0]    o_top_value,
    output logic                 o_top_valid,
    output logic [CNT_OUT_W-1:0] o_stack_count
);
    `include "assert_macros.svh"

    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam int QAW  = $clog2(QUEUE_DEPTH);
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int QSW  = $clog2(2 * QUEUE_DEPTH);
    localparam int MAXD = (STACK_DEPTH > QUEUE_DEPTH) ? STACK_DEPTH : QUEUE_DEPTH;
    localparam int IW   = $clog2(MAXD + 1);
    localparam int EW   = (CNTW > CNT_OUT_W) ? CNTW : CNT_OUT_W;

    logic [DATA_W-1:0] ws [STACK_DEPTH];
    logic [DATA_W-1:0] ks [STACK_DEPTH];
    logic [DATA_W-1:0] wq [QUEUE_DEPTH];
    logic [DATA_W-1:0] kq [QUEUE_DEPTH];

    logic [DATA_W-1:0] r_srd, r_krd, r_qrd, r_kqrd;
    logic [DATA_W-1:0] r_b, r_a, r_res;
    logic [NUM_W-1:0]  r_num;
    logic [CNTW-1:0]   r_cnt, r_kcnt, n_cnt;
    logic [QAW-1:0]    r_head, r_khead;
    logic [FW-1:0]     r_fill, r_kfill;
    logic [IW-1:0]     r_idx;
    logic              r_ovalid;
    logic [STAT_W-1:0] r_ostatus;
    logic [DATA_W-1:0] r_otop;
    logic              r_otopok;
    logic [CNTW-1:0]   r_ocnt;

    logic [CNTW-1:0]   rd_cnt, wr_cnt;
    logic [SAW-1:0]    s_rd_addr, s_wr_addr;
    logic [DATA_W-1:0] s_wr_data;
    logic [QSW-1:0]    q_sum;
    logic [QAW-1:0]    q_tail, q_head_nx, q_rd_addr;
    logic [IW-1:0]     wi;
    logic              copy_on, ws_cp, wq_cp;
    logic              div_busy, div_done;
    logic [DATA_W-1:0] div_q;
    logic [EW-1:0]     cnt_ext;

    rsq_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_busy (div_busy),
        .o_done (div_done),
        .o_q    (div_q)
    );

    // copy sweep writes the entry read in the previous cycle
    assign copy_on = i_cmd.copy_save | i_cmd.copy_load;
    assign wi      = r_idx - 1'b1;
    assign ws_cp   = (r_idx != '0) && (wi < IW'(STACK_DEPTH));
    assign wq_cp   = (r_idx != '0) && (wi < IW'(QUEUE_DEPTH));

    assign rd_cnt    = r_cnt - CNTW'(i_cmd.srd_off);
    assign s_rd_addr = i_cmd.copy_save ? r_idx[SAW-1:0] : rd_cnt[SAW-1:0];

    always_comb begin
        case (i_cmd.sw_addr)
            SA_M2:   wr_cnt = r_cnt - CNTW'(2);
            SA_M3:   wr_cnt = r_cnt - CNTW'(3);
            default: wr_cnt = r_cnt;
        endcase
        s_wr_addr = wr_cnt[SAW-1:0];
        case (i_cmd.sw_data)
            SD_RES:  s_wr_data = r_res;
            SD_SRD:  s_wr_data = r_srd;
            SD_COND: s_wr_data = (r_b != '0) ? r_srd : r_a;
            SD_QRD:  s_wr_data = r_qrd;
            default: s_wr_data = {1'b0, r_num};
        endcase
    end

    assign q_sum     = QSW'(r_head) + QSW'(r_fill);
    assign q_tail    = (q_sum >= QSW'(QUEUE_DEPTH)) ? QAW'(q_sum - QSW'(QUEUE_DEPTH))
                                                    : QAW'(q_sum);
    assign q_head_nx = (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign q_rd_addr = i_cmd.copy_save ? r_idx[QAW-1:0] : r_head;

    // memories
    always_ff @(posedge i_clk) begin
        r_srd <= ws[s_rd_addr];
        if (i_cmd.copy_load && ws_cp) begin
            ws[wi[SAW-1:0]] <= r_krd;
        end else if (i_cmd.sw_en) begin
            ws[s_wr_addr] <= s_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_krd <= ks[r_idx[SAW-1:0]];
        if (i_cmd.copy_save && ws_cp) begin
            ks[wi[SAW-1:0]] <= r_srd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qrd <= wq[q_rd_addr];
        if (i_cmd.copy_load && wq_cp) begin
            wq[wi[QAW-1:0]] <= r_kqrd;
        end else if (i_cmd.qwr) begin
            wq[q_tail] <= r_srd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kqrd <= kq[r_idx[QAW-1:0]];
        if (i_cmd.copy_save && wq_cp) begin
            kq[wi[QAW-1:0]] <= r_qrd;
        end
    end

    // operand capture and alu
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_num) r_num <= i_number;
        if (i_cmd.cap_b)    r_b   <= r_srd;
        if (i_cmd.cap_a)    r_a   <= r_srd;
        if (i_cmd.div_cap) begin
            r_res <= div_q;
        end else if (i_cmd.alu) begin
            case (i_cmd.alu_op)
                MODE_ADD: r_res <= r_a + r_b;
                MODE_SUB: r_res <= r_a - r_b;
                default:  r_res <= r_a * r_b;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC:  n_cnt = r_cnt + 1'b1;
            CNT_DEC:  n_cnt = r_cnt - 1'b1;
            CNT_DEC2: n_cnt = r_cnt - CNTW'(2);
            default:  n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_kcnt  <= '0;
            r_head  <= '0;
            r_khead <= '0;
            r_fill  <= '0;
            r_kfill <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load_regs) begin
                r_cnt  <= r_kcnt;
                r_head <= r_khead;
                r_fill <= r_kfill;
            end else begin
                r_cnt <= n_cnt;
                if (i_cmd.qwr) begin
                    r_fill <= r_fill + 1'b1;
                end else if (i_cmd.qpop) begin
                    r_fill <= r_fill - 1'b1;
                    r_head <= q_head_nx;
                end
            end
            if (i_cmd.save_regs) begin
                r_kcnt  <= r_cnt;
                r_khead <= r_head;
                r_kfill <= r_fill;
            end
            if (i_cmd.copy_clr) begin
                r_idx <= '0;
            end else if (copy_on) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostatus <= i_cmd.status;
            r_otopok  <= i_cmd.top_ok;
            r_otop    <= i_cmd.top_ok ? r_b : '0;
            r_ocnt    <= r_cnt;
        end
    end

    assign cnt_ext       = EW'(r_ocnt);
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_top_value   = r_otop;
    assign o_top_valid   = r_otopok;
    assign o_stack_count = cnt_ext[CNT_OUT_W-1:0];

    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.cnt_lt2   = (r_cnt < CNTW'(2));
    assign o_stat.cnt_lt3   = (r_cnt < CNTW'(3));
    assign o_stat.cnt_full  = (r_cnt >= CNTW'(STACK_DEPTH));
    assign o_stat.q_empty   = (r_fill == '0);
    assign o_stat.q_full    = (r_fill >= FW'(QUEUE_DEPTH));
    assign o_stat.b_zero    = (r_b == '0);
    assign o_stat.div_done  = div_done;
    assign o_stat.copy_done = (r_idx == IW'(MAXD));
    assign o_stat.out_busy  = r_ovalid & ~i_ready;

    `RSQ_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CNTW'(STACK_DEPTH))
    `RSQ_NEVER(a_fill_range, i_clk, i_rst_n, r_fill > FW'(QUEUE_DEPTH))
    `RSQ_NEVER(a_div_overlap, i_clk, i_rst_n, i_cmd.div_start && div_busy)
    `RSQ_NEVER(a_out_overrun, i_clk, i_rst_n, i_cmd.out_load && r_ovalid && !i_ready)
endmodule

[rtl/rsq_ctrl.sv]
// controller: sequences each command over the datapath
module rsq_ctrl
    import rsq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_B    = 4'd2;
    localparam logic [3:0] S_A    = 4'd3;
    localparam logic [3:0] S_EX   = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_C    = 4'd7;
    localparam logic [3:0] S_Q    = 4'd8;
    localparam logic [3:0] S_COPY = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_topok, n_topok;

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_topok  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_topok  <= n_topok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_mode <= i_mode;
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.alu_op = r_mode;
        o_cmd.status = r_status;
        o_cmd.top_ok = r_topok;
        n_state      = r_state;
        n_status     = r_status;
        n_topok      = r_topok;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take_num = 1'b1;
                    n_state        = S_DEC;
                end
            end
            S_DEC: begin
                n_status = ST_OK;
                n_topok  = 1'b0;
                n_state  = S_FIN;
                case (r_mode)
                    MODE_PUSH: begin
                        if (i_stat.cnt_full) begin
                            n_status = ST_SFULL;
                        end else begin
                            o_cmd.sw_en   = 1'b1;
                            o_cmd.sw_addr = SA_CNT;
                            o_cmd.sw_data = SD_NUM;
                            o_cmd.cnt_op  = CNT_INC;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                        if (i_stat.cnt_lt2) begin
                            n_status = ST_FEW;
                        end else begin
                            o_cmd.srd_off = 2'd1;
                            n_state       = S_B;
                        end
                    end
                    MODE_TOP: begin
                        if (i_stat.cnt_zero) begin
                            n_status = ST_FEW;
                        end else begin
                            o_cmd.srd_off = 2'd1;
                            n_state       = S_B;
                        end
                    end
                    MODE_POP: begin
                        if (i_stat.cnt_zero) n_status = ST_FEW;
                        else o_cmd.cnt_op = CNT_DEC;
                    end
                    MODE_DUP: begin
                        if (i_stat.cnt_zero) begin
                            n_status = ST_FEW;
                        end else if (i_stat.cnt_full) begin
                            n_status = ST_SFULL;
                        end else begin
                            o_cmd.srd_off = 2'd1;
                            n_state       = S_B;
                        end
                    end
                    MODE_COND: begin
                        if (i_stat.cnt_lt3) begin
                            n_status = ST_FEW;
                        end else begin
                            o_cmd.srd_off = 2'd1;
                            n_state       = S_B;
                        end
                    end
                    MODE_ENQ: begin
                        if (i_stat.cnt_zero) begin
                            n_status = ST_FEW;
                        end else if (i_stat.q_full) begin
                            n_status = ST_QFULL;
                        end else begin
                            o_cmd.srd_off = 2'd1;
                            n_state       = S_B;
                        end
                    end
                    MODE_DEQ: begin
                        if (i_stat.q_empty) n_status = ST_QEMPTY;
                        else if (i_stat.cnt_full) n_status = ST_SFULL;
                        else n_state = S_Q;
                    end
                    MODE_SAVE: begin
                        o_cmd.save_regs = 1'b1;
                        o_cmd.copy_clr  = 1'b1;
                        n_state         = S_COPY;
                    end
                    MODE_LOAD: begin
                        o_cmd.load_regs = 1'b1;
                        o_cmd.copy_clr  = 1'b1;
                        n_state         = S_COPY;
                    end
                    default: n_status = ST_UNKNOWN;
                endcase
            end
            S_B: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_FIN;
                case (r_mode)
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_COND: begin
                        o_cmd.srd_off = 2'd2;
                        n_state       = S_A;
                    end
                    MODE_TOP: n_topok = 1'b1;
                    MODE_DUP: begin
                        o_cmd.sw_en   = 1'b1;
                        o_cmd.sw_addr = SA_CNT;
                        o_cmd.sw_data = SD_SRD;
                        o_cmd.cnt_op  = CNT_INC;
                    end
                    MODE_ENQ: begin
                        o_cmd.qwr    = 1'b1;
                        o_cmd.cnt_op = CNT_DEC;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_A: begin
                o_cmd.cap_a = 1'b1;
                if (r_mode == MODE_COND) begin
                    o_cmd.srd_off = 2'd3;
                    n_state       = S_C;
                end else begin
                    n_state = S_EX;
                end
            end
            S_EX: begin
                if (r_mode == MODE_DIV) begin
                    if (i_stat.b_zero) begin
                        // divisor dropped, dividend stays
                        o_cmd.cnt_op = CNT_DEC;
                        n_status     = ST_DIV0;
                        n_state      = S_FIN;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.alu = 1'b1;
                    n_state   = S_WR;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = S_WR;
                end
            end
            S_WR: begin
                o_cmd.sw_en   = 1'b1;
                o_cmd.sw_addr = SA_M2;
                o_cmd.sw_data = SD_RES;
                o_cmd.cnt_op  = CNT_DEC;
                n_state       = S_FIN;
            end
            S_C: begin
                o_cmd.sw_en   = 1'b1;
                o_cmd.sw_addr = SA_M3;
                o_cmd.sw_data = SD_COND;
                o_cmd.cnt_op  = CNT_DEC2;
                n_state       = S_FIN;
            end
            S_Q: begin
                o_cmd.sw_en   = 1'b1;
                o_cmd.sw_addr = SA_CNT;
                o_cmd.sw_data = SD_QRD;
                o_cmd.cnt_op  = CNT_INC;
                o_cmd.qpop    = 1'b1;
                n_state       = S_FIN;
            end
            S_COPY: begin
                o_cmd.copy_save = (r_mode == MODE_SAVE);
                o_cmd.copy_load = (r_mode != MODE_SAVE);
                if (i_stat.copy_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[test/rpn_stack_queue_calculator_test.sv]
// testbench for the rpn stack and queue calculator: directed and random commands
module rpn_stack_queue_calculator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rsq_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int QUEUE_DEPTH = 64;
    localparam logic [MODE_W-1:0] MODE_BAD  = 4'd13;
    localparam logic [MODE_W-1:0] MODE_LAST = 4'd15;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NUM_W-1:0]  number;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [DATA_W-1:0]    top_value;
        logic                 top_valid;
        logic [CNT_OUT_W-1:0] stack_count;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // mode[3:0], number[34:4], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // status[2:0], top_value[34:3], top_valid[35],
                            // stack_count[42:36], zero pad

    rpn_stack_queue_calculator #(
        .STACK_DEPTH(STACK_DEPTH),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // predicted machine state
    logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
    logic [DATA_W-1:0] calc_fifo  [QUEUE_DEPTH];
    logic [DATA_W-1:0] saved_stack[STACK_DEPTH];
    logic [DATA_W-1:0] saved_fifo [QUEUE_DEPTH];
    int calc_depth, calc_head, calc_fill;
    int saved_depth, saved_head, saved_fill;

    t_cmd    cmd_queue[$];
    t_answer answer_queue[$];
    int      mismatches;
    bit      stim_done;
    int      burst_left, gap_left, stall_phase;
    // tracks whether the item on the bus was left unaccepted at the last edge
    logic    s_tready_q;

    function automatic logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] ma, mb, q;
        ma = a[DATA_W-1] ? -a : a;
        mb = b[DATA_W-1] ? -b : b;
        q = ma / mb;
        return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
    endfunction

    function automatic t_answer calc_step(t_cmd c);
        t_answer r;
        logic [DATA_W-1:0] a, b;
        int n;
        r = '0;
        r.status = ST_OK;
        n = calc_depth;
        case (c.mode)
            MODE_PUSH: begin
                if (n >= STACK_DEPTH) r.status = ST_SFULL;
                else begin
                    calc_stack[n] = {1'b0, c.number};
                    calc_depth = n + 1;
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                if (n < 2) r.status = ST_FEW;
                else begin
                    b = calc_stack[n-1];
                    a = calc_stack[n-2];
                    calc_depth = n - 1;
                    if (c.mode == MODE_DIV && b == 0) r.status = ST_DIV0;
                    else if (c.mode == MODE_ADD) calc_stack[n-2] = a + b;
                    else if (c.mode == MODE_SUB) calc_stack[n-2] = a - b;
                    else if (c.mode == MODE_MUL) calc_stack[n-2] = a * b;
                    else calc_stack[n-2] = quotient(a, b);
                end
            end
            MODE_TOP: begin
                if (n == 0) r.status = ST_FEW;
                else begin
                    r.top_value = calc_stack[n-1];
                    r.top_valid = 1'b1;
                end
            end
            MODE_POP: begin
                if (n == 0) r.status = ST_FEW;
                else calc_depth = n - 1;
            end
            MODE_DUP: begin
                if (n == 0) r.status = ST_FEW;
                else if (n >= STACK_DEPTH) r.status = ST_SFULL;
                else begin
                    calc_stack[n] = calc_stack[n-1];
                    calc_depth = n + 1;
                end
            end
            MODE_COND: begin
                if (n < 3) r.status = ST_FEW;
                else begin
                    calc_stack[n-3] = (calc_stack[n-1] != 0) ? calc_stack[n-3]
                                                             : calc_stack[n-2];
                    calc_depth = n - 2;
                end
            end
            MODE_ENQ: begin
                if (n == 0) r.status = ST_FEW;
                else if (calc_fill >= QUEUE_DEPTH) r.status = ST_QFULL;
                else begin
                    calc_fifo[(calc_head + calc_fill) % QUEUE_DEPTH] = calc_stack[n-1];
                    calc_fill++;
                    calc_depth = n - 1;
                end
            end
            MODE_DEQ: begin
                if (calc_fill == 0) r.status = ST_QEMPTY;
                else if (n >= STACK_DEPTH) r.status = ST_SFULL;
                else begin
                    calc_stack[n] = calc_fifo[calc_head];
                    calc_depth = n + 1;
                    calc_head = (calc_head + 1) % QUEUE_DEPTH;
                    calc_fill--;
                end
            end
            MODE_SAVE: begin
                saved_stack = calc_stack;
                saved_fifo = calc_fifo;
                saved_depth = calc_depth;
                saved_head = calc_head;
                saved_fill = calc_fill;
            end
            MODE_LOAD: begin
                calc_stack = saved_stack;
                calc_fifo = saved_fifo;
                calc_depth = saved_depth;
                calc_head = saved_head;
                calc_fill = saved_fill;
            end
            default: r.status = ST_UNKNOWN;
        endcase
        r.stack_count = calc_depth[CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] pick_number();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return NUM_W'($urandom_range(0, 9));
            3: return {1'b1, 30'($urandom)};
            default: return NUM_W'($urandom);
        endcase
    endfunction

    task automatic add_cmd(logic [MODE_W-1:0] m, logic [NUM_W-1:0] v);
        cmd_queue.push_back('{mode: m, number: v});
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // driver: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin
        t_cmd c;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else if (!(s_tvalid && !s_tready_q)) begin
            // previous item was taken (or none was offered)
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                c = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {5'b0, c.number, c.mode};
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cmd c;
        t_answer got, want;
        s_tready_q <= !(i_rst_n && s_tvalid && !s_tready);
        if (i_rst_n && s_tvalid && s_tready) begin
            c.mode = s_tdata[3:0];
            c.number = s_tdata[34:4];
            answer_queue.push_back(calc_step(c));
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{status: m_tdata[2:0], top_value: m_tdata[34:3],
                    top_valid: m_tdata[35], stack_count: m_tdata[42:36]};
            if (answer_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = answer_queue.pop_front();
                if (got !== want || m_tdata[47:43] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d top %h/%h valid %0d/%0d count %0d/%0d",
                                 want.status, got.status, want.top_value, got.top_value,
                                 want.top_valid, got.top_valid,
                                 want.stack_count, got.stack_count);
                end
            end
        end
    end

    // receiver stall pattern: alternating open and throttled windows
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) m_tready <= 1'b0;
        else if (stall_phase[9]) m_tready <= 1'b1;
        else if (stall_phase[6]) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 4) == 0);
    end

    initial begin
        int kind, len;
        logic [MODE_W-1:0] m;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        s_tready_q = 1'b1;
        stall_phase = 0;
        burst_left = 0;
        gap_left = 0;
        mismatches = 0;
        calc_depth = 0; calc_head = 0; calc_fill = 0;
        saved_depth = 0; saved_head = 0; saved_fill = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: errors on empty state, extremes, each operation
        add_cmd(MODE_ADD, '0);
        add_cmd(MODE_TOP, '0);
        add_cmd(MODE_POP, '0);
        add_cmd(MODE_DUP, '0);
        add_cmd(MODE_ENQ, '0);
        add_cmd(MODE_DEQ, '0);
        add_cmd(MODE_BAD, '1);
        add_cmd(MODE_LAST, '0);
        add_cmd(MODE_PUSH, '1);
        add_cmd(MODE_PUSH, '0);
        add_cmd(MODE_COND, '0);
        add_cmd(MODE_DIV, '0);
        add_cmd(MODE_PUSH, 31'd1);
        add_cmd(MODE_ADD, '0);
        add_cmd(MODE_PUSH, 31'd0);
        add_cmd(MODE_PUSH, 31'd1);
        add_cmd(MODE_SUB, '0);
        add_cmd(MODE_DIV, '0);
        add_cmd(MODE_TOP, '0);
        add_cmd(MODE_PUSH, 31'd3);
        add_cmd(MODE_MUL, '0);
        add_cmd(MODE_DUP, '0);
        add_cmd(MODE_SAVE, '0);
        add_cmd(MODE_ENQ, '0);
        add_cmd(MODE_LOAD, '0);

        // random: mostly sensible programs, with stretches that fill the stack or queue
        while (cmd_queue.size() < 1000) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                len = $urandom_range(STACK_DEPTH, STACK_DEPTH + 3);
                repeat (len) add_cmd(($urandom_range(0, 1) ? MODE_PUSH : MODE_DUP),
                                     pick_number());
            end else if (kind == 1) begin
                len = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 3);
                repeat (len) begin
                    add_cmd(MODE_PUSH, pick_number());
                    add_cmd(MODE_ENQ, '0);
                end
            end else if (kind == 2) begin
                repeat ($urandom_range(1, 70)) add_cmd(MODE_DEQ, '0);
            end else if (kind < 6) begin
                add_cmd(MODE_PUSH, pick_number());
                add_cmd(MODE_PUSH, pick_number());
                add_cmd(MODE_PUSH, pick_number());
                add_cmd(4'($urandom_range(1, 4)), '0);
                add_cmd(MODE_TOP, '0);
            end else begin
                m = 4'($urandom_range(0, 15));
                add_cmd(m, pick_number());
            end
        end
        // take the stack down to cover small depths before the end
        repeat (70) add_cmd(MODE_POP, '0);
        add_cmd(MODE_LOAD, '0);
        add_cmd(MODE_TOP, '0);

        wait (cmd_queue.size() == 0 && !s_tvalid);
        wait (answer_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && answer_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
